FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros included by the RTL core to check its own logic.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/lsp_gen_pkg.sv
// ----------------------------------------------------------------------------
// lsp_gen_pkg
// Types, codes and constants of the LED strip pattern generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lsp_gen_pkg;

  localparam int NUM_PIXELS_DEF = 16;

  localparam logic [7:0] LEVEL_MAX  = 8'd255;
  localparam logic [7:0] RED_BLINK  = 8'd250;
  localparam logic [7:0] BLINK_RESET = 8'd10;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_SET  = 1'b1;

  localparam logic REG_BLINK_INTERVAL = 1'b0;

  typedef enum logic [2:0] {
    STATUS_IDLE   = 3'd0,
    STATUS_UNDOCK = 3'd1,
    STATUS_DOCK   = 3'd2,
    STATUS_NETERR = 3'd3,
    STATUS_ERROR  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    GEN_READY,
    GEN_LOAD,
    GEN_FRAME
  } gen_state_t;

  typedef struct packed {
    logic       mode;
    logic [2:0] status;
  } in_item_t;

  typedef struct packed {
    logic [5:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/lsp_gen_ram.sv
// ----------------------------------------------------------------------------
// lsp_gen_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lsp_gen_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/led_strip_pattern_generator_core.sv
// ----------------------------------------------------------------------------
// led_strip_pattern_generator_core
// Animation sequencer for a strip of NUM_PIXELS pixels: idle blue ramp,
// staggered green waves while docking or undocking, red blink on error.
// ----------------------------------------------------------------------------
// An animation tick that produces a frame emits NUM_PIXELS items, one per
// cycle when the output is not stalled, and the block takes its next item
// only once the last pixel of the frame has moved into the output register.
// In the wave modes each pixel is read from the pixel RAM, stepped and
// written back, one pixel per cycle while the output is not stalled. A
// set-status item for docking or undocking loads every RAM entry before the
// next item is taken. A blink tick that falls between blinks emits nothing.
`default_nettype none

module led_strip_pattern_generator_core #(
  parameter int NUM_PIXELS = lsp_gen_pkg::NUM_PIXELS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire lsp_gen_pkg::in_item_t in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output lsp_gen_pkg::out_item_t     out_item,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);

  localparam int IDX_W = $clog2(NUM_PIXELS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PIXELS - 1);
  localparam logic [7:0] LEVEL_STEP = 8'(255 / NUM_PIXELS);
  localparam logic [8:0] WAVE_STEP  = 9'(2 * (255 / NUM_PIXELS));

  lsp_gen_pkg::gen_state_t state, state_next;
  lsp_gen_pkg::status_t    cur_status;
  logic [8:0]       phase;
  logic             phase_dir;
  logic [7:0]       blink;
  logic [7:0]       frame_red;
  logic [7:0]       frame_blue;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_busy;
  logic             s1_valid;
  logic [IDX_W-1:0] s1_idx;
  logic [IDX_W-1:0] ld_idx;
  logic [7:0]       ld_level;
  logic             ld_dir;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [8:0]       ram_wdata;
  logic             ram_re;
  logic [8:0]       ram_rdata;

  logic       in_fire, cfg_write;
  logic       is_wave, is_err, blink_due;
  logic [2:0] set_code;
  logic       set_wave;
  logic       out_free, issue, advance, frame_done;
  logic       tick_frame;
  logic       in_load, load_last;
  logic [7:0] lv;
  logic       lv_dir;
  logic [8:0] lv_sum;
  logic [7:0] wave_level;
  logic       wave_dir;
  logic [8:0] idle_step;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == lsp_gen_pkg::REG_BLINK_INTERVAL) ? {24'd0, blink} : 32'd0;

  assign in_fire  = in_valid && !in_stall;
  assign is_wave  = (cur_status == lsp_gen_pkg::STATUS_UNDOCK) ||
                    (cur_status == lsp_gen_pkg::STATUS_DOCK);
  assign is_err   = (cur_status == lsp_gen_pkg::STATUS_NETERR) ||
                    (cur_status == lsp_gen_pkg::STATUS_ERROR);
  assign blink_due = phase > {1'b0, blink};
  assign set_code = (in_item.status > 3'(lsp_gen_pkg::STATUS_ERROR)) ?
                    3'(lsp_gen_pkg::STATUS_ERROR) : in_item.status;
  assign set_wave = (set_code == 3'(lsp_gen_pkg::STATUS_UNDOCK)) ||
                    (set_code == 3'(lsp_gen_pkg::STATUS_DOCK));
  assign tick_frame = !is_err || blink_due;

  assign out_free   = !out_valid || !out_stall;
  assign advance    = (state == lsp_gen_pkg::GEN_FRAME) && s1_valid && out_free;
  assign issue      = (state == lsp_gen_pkg::GEN_FRAME) && rd_busy &&
                      (!s1_valid || advance);
  assign frame_done = advance && (s1_idx == LAST_IDX);
  assign in_load    = (state == lsp_gen_pkg::GEN_LOAD);
  assign load_last  = in_load && (ld_idx == LAST_IDX);

  // Step one pixel of the green wave.
  assign lv     = ram_rdata[7:0];
  assign lv_dir = ram_rdata[8];
  assign lv_sum = {1'b0, lv} + WAVE_STEP;
  always_comb begin
    if (lv_dir) begin
      if (lv_sum >= {1'b0, lsp_gen_pkg::LEVEL_MAX}) begin
        wave_level = lsp_gen_pkg::LEVEL_MAX;
        wave_dir   = 1'b0;
      end else begin
        wave_level = lv_sum[7:0];
        wave_dir   = 1'b1;
      end
    end else begin
      if ({1'b0, lv} <= WAVE_STEP) begin
        wave_level = 8'd0;
        wave_dir   = 1'b1;
      end else begin
        wave_level = lv - WAVE_STEP[7:0];
        wave_dir   = 1'b0;
      end
    end
  end

  assign idle_step = phase_dir ? (phase + 9'd1) : (phase - 9'd1);

  always_comb begin
    state_next = state;
    case (state)
      lsp_gen_pkg::GEN_READY: begin
        if (in_fire) begin
          if (in_item.mode == lsp_gen_pkg::MODE_SET) begin
            if (set_wave) state_next = lsp_gen_pkg::GEN_LOAD;
          end else if (tick_frame) begin
            state_next = lsp_gen_pkg::GEN_FRAME;
          end
        end
      end
      lsp_gen_pkg::GEN_LOAD: begin
        if (ld_idx == LAST_IDX) state_next = lsp_gen_pkg::GEN_READY;
      end
      lsp_gen_pkg::GEN_FRAME: begin
        if (frame_done) state_next = lsp_gen_pkg::GEN_READY;
      end
      default: state_next = lsp_gen_pkg::GEN_READY;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = s1_idx;
    ram_wdata = {wave_dir, wave_level};
    ram_re    = issue;
    case (state)
      lsp_gen_pkg::GEN_READY: begin
        in_stall = 1'b0;
      end
      lsp_gen_pkg::GEN_LOAD: begin
        ram_we    = 1'b1;
        ram_waddr = ld_idx;
        ram_wdata = {ld_dir, ld_level};
      end
      lsp_gen_pkg::GEN_FRAME: begin
        ram_we = advance && is_wave;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  lsp_gen_ram #(
    .WIDTH(9),
    .DEPTH(NUM_PIXELS)
  ) u_pixel_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(rd_idx),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lsp_gen_pkg::GEN_READY;
      cur_status <= lsp_gen_pkg::STATUS_IDLE;
      phase      <= 9'd0;
      phase_dir  <= 1'b1;
      blink      <= lsp_gen_pkg::BLINK_RESET;
      rd_busy    <= 1'b0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write && (paddr[2] == lsp_gen_pkg::REG_BLINK_INTERVAL)) begin
        blink <= pwdata[7:0];
      end

      if (in_fire) begin
        if (in_item.mode == lsp_gen_pkg::MODE_SET) begin
          cur_status <= lsp_gen_pkg::status_t'(set_code);
          if (set_wave) begin
            ld_idx   <= '0;
            ld_level <= 8'd0;
            ld_dir   <= (set_code == 3'(lsp_gen_pkg::STATUS_DOCK));
          end else begin
            phase     <= 9'd0;
            phase_dir <= 1'b1;
          end
        end else begin
          if (tick_frame) begin
            rd_idx  <= '0;
            rd_busy <= 1'b1;
          end
          if (cur_status == lsp_gen_pkg::STATUS_IDLE) begin
            frame_blue <= phase[7:0];
            phase      <= idle_step;
            if (idle_step >= {1'b0, lsp_gen_pkg::LEVEL_MAX}) begin
              phase_dir <= 1'b0;
            end else if (idle_step == 9'd0) begin
              phase_dir <= 1'b1;
            end
          end else if (is_err) begin
            if (blink_due) begin
              frame_red <= phase_dir ? lsp_gen_pkg::RED_BLINK : 8'd0;
              phase     <= 9'd1;
              phase_dir <= !phase_dir;
            end else begin
              phase <= phase + 9'd1;
            end
          end
        end
      end

      if (state == lsp_gen_pkg::GEN_LOAD) begin
        ld_idx   <= ld_idx + 1'b1;
        ld_level <= ld_level + LEVEL_STEP;
      end

      if (issue) begin
        s1_valid <= 1'b1;
        s1_idx   <= rd_idx;
        rd_idx   <= rd_idx + 1'b1;
        if (rd_idx == LAST_IDX) rd_busy <= 1'b0;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end

      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item.pixel_index <= 6'(s1_idx);
      out_item.red         <= is_err ? frame_red : 8'd0;
      out_item.green       <= is_wave ? lv : 8'd0;
      out_item.blue        <= (cur_status == lsp_gen_pkg::STATUS_IDLE) ? frame_blue : 8'd0;
      out_item.last_pixel  <= (s1_idx == LAST_IDX);
    end
  end

`include "assert_macros.svh"

  `ASSERT_IMPLIES(a_load_no_frame, clk, rst, in_load, !s1_valid && !rd_busy)
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_item))
  `ASSERT_NEXT(a_load_end, clk, rst, load_last, state == lsp_gen_pkg::GEN_READY)

endmodule

`default_nettype wire

FILE: tb/sv/tb_led_strip_pattern_generator_core.sv
// ----------------------------------------------------------------------------
// tb_led_strip_pattern_generator_core
// Drives set-status items and animation ticks into the pattern generator,
// predicts every pixel color of each frame (idle blue ramp, green waves,
// red blink) and checks the output stream item by item, with random gaps
// on the input and random stalls on the output outside the calm phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_led_strip_pattern_generator_core;
  import lsp_gen_pkg::*;

  localparam int NPIX = NUM_PIXELS_DEF;
  localparam int SEED_STEP = int'(LEVEL_MAX) / NPIX;
  localparam int WAVE_STEP = 2 * SEED_STEP;
  localparam logic [2:0] GAP_ADDR = {REG_BLINK_INTERVAL, 2'b00};

  class pixel_color_tracker;
    logic [7:0] blink_gap;
    status_t    mode_now;
    logic [8:0] ramp;
    logic       ramp_up;
    logic [7:0] level [NPIX];
    logic       climbing [NPIX];
    out_item_t  pending [$];
    int         mismatches;

    function new();
      blink_gap = BLINK_RESET;
      mode_now = STATUS_IDLE;
      ramp = '0;
      ramp_up = 1'b1;
      mismatches = 0;
    endfunction

    function void queue_pixel(int k, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      out_item_t px;
      px.pixel_index = 6'(k);
      px.red = r;
      px.green = g;
      px.blue = b;
      px.last_pixel = (k == NPIX - 1);
      pending = {pending, px};
    endfunction

    function void take_command(in_item_t it);
      int lv;
      logic [7:0] shade;
      if (it.mode == MODE_SET) begin
        mode_now = (it.status > STATUS_ERROR) ? STATUS_ERROR : status_t'(it.status);
        if (mode_now == STATUS_UNDOCK || mode_now == STATUS_DOCK) begin
          for (int k = 0; k < NPIX; k++) begin
            level[k] = 8'(k * SEED_STEP);
            climbing[k] = (mode_now == STATUS_DOCK);
          end
        end else begin
          ramp = '0;
          ramp_up = 1'b1;
        end
        return;
      end
      case (mode_now)
        STATUS_IDLE: begin
          for (int k = 0; k < NPIX; k++) queue_pixel(k, 8'd0, 8'd0, ramp[7:0]);
          ramp = ramp_up ? ramp + 9'd1 : ramp - 9'd1;
          if (ramp >= 9'(LEVEL_MAX)) ramp_up = 1'b0;
          else if (ramp == 9'd0) ramp_up = 1'b1;
        end
        STATUS_UNDOCK, STATUS_DOCK: begin
          for (int k = 0; k < NPIX; k++) begin
            queue_pixel(k, 8'd0, level[k], 8'd0);
            lv = climbing[k] ? int'(level[k]) + WAVE_STEP : int'(level[k]) - WAVE_STEP;
            if (lv >= int'(LEVEL_MAX)) begin
              lv = int'(LEVEL_MAX);
              climbing[k] = 1'b0;
            end else if (lv <= 0) begin
              lv = 0;
              climbing[k] = 1'b1;
            end
            level[k] = 8'(lv);
          end
        end
        default: begin
          if (ramp > {1'b0, blink_gap}) begin
            shade = ramp_up ? RED_BLINK : 8'd0;
            for (int k = 0; k < NPIX; k++) queue_pixel(k, shade, 8'd0, 8'd0);
            ramp = '0;
            ramp_up = !ramp_up;
          end
          ramp = ramp + 9'd1;
        end
      endcase
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_pixel(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: pixel %0d expected none actual red %0d green %0d blue %0d",
                 $time, got.pixel_index, got.red, got.green, got.blue);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      compare("pixel_index", want.pixel_index, got.pixel_index);
      compare("red", want.red, got.red);
      compare("green", want.green, got.green);
      compare("blue", want.blue, got.blue);
      compare("last_pixel", want.last_pixel, got.last_pixel);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        calm = 1'b0;

  pixel_color_tracker board;

  led_strip_pattern_generator_core uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_pixel(out_item);
    out_stall <= !calm && ($urandom_range(0, 99) < 17);
  end

  task automatic push_command(logic mode, logic [2:0] status);
    in_item_t it;
    it.mode = mode;
    it.status = status;
    while (!calm && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    board.take_command(it);
  endtask

  task automatic tick();
    push_command(MODE_TICK, 3'($urandom_range(0, 7)));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (NPIX + 4) @(posedge clk);
  endtask

  task automatic write_gap(logic [7:0] gap);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= GAP_ADDR;
    pwdata <= {24'd0, gap};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.blink_gap = gap;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== gap) begin
      $display("%0t: blink interval expected %0d actual %0d", $time, gap, prdata[7:0]);
      board.mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(logic [7:0] gap, int span, status_t lead, int lead_len);
    int done;
    int n;
    settle();
    write_gap(gap);
    if (lead_len > 0) begin
      push_command(MODE_SET, lead);
      repeat (lead_len) tick();
    end
    done = 0;
    while (done < span) begin
      if ($urandom_range(0, 9) < 8) begin
        push_command(MODE_SET, 3'($urandom_range(0, 7)));
        n = $urandom_range(1, 24);
        repeat (n) tick();
        done += n + 1;
      end else begin
        push_command(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
        done++;
      end
    end
  endtask

  initial begin
    board = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    push_command(MODE_TICK, 3'd0);
    push_command(MODE_TICK, 3'd7);
    push_command(MODE_SET, STATUS_DOCK);
    tick();
    tick();
    push_command(MODE_SET, STATUS_UNDOCK);
    tick();
    tick();
    push_command(MODE_SET, 3'd7);
    tick();
    tick();
    settle();
    write_gap(8'd0);
    tick();
    tick();
    push_command(MODE_SET, 3'd6);
    tick();
    tick();
    push_command(MODE_SET, STATUS_NETERR);
    tick();
    tick();
    push_command(MODE_SET, 3'd5);
    tick();
    push_command(MODE_SET, STATUS_IDLE);
    tick();

    run_phase(BLINK_RESET, 20, STATUS_IDLE, 262);
    run_phase(8'd255, 20, STATUS_NETERR, 10);
    calm = 1'b1;
    run_phase(8'd1, 35, STATUS_ERROR, 0);
    calm = 1'b0;
    run_phase(8'($urandom_range(2, 254)), 20, STATUS_DOCK, 20);
    run_phase(8'd0, 20, STATUS_ERROR, 6);

    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (NPIX + 6) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      if (board.pending.size() != 0)
        $display("%0t: %0d expected pixels never arrived", $time, board.pending.size());
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
